// ===== hw/rtl/b64sc_pkg.sv =====
`timescale 1ns / 1ps

package b64sc_pkg;

	// The most results that one request can produce (an encode flush).
	localparam int MAX_RUN = 4;
	localparam int RUN_CNT_W = $clog2(MAX_RUN + 1);

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// Element 63 holds 'A', so the character for a six-bit value v sits at 63 - v.
	localparam logic [63:0][7:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	// All results caused by one request, in output order.
	typedef struct packed {
		logic [RUN_CNT_W-1:0] count;
		logic [MAX_RUN-1:0][7:0] chars;
		logic eom;
	} run_t;

	typedef struct packed {
		logic valid;
		run_t run;
	} push_t;

	typedef struct packed {
		logic ok;
		logic [5:0] value;
	} symbol_t;

	function automatic logic [7:0] enc_char(input logic [5:0] six);
		return ALPHABET[6'd63 - six];
	endfunction

	function automatic symbol_t symbol_value(input logic [7:0] c);
		symbol_t s;
		s.ok = 1'b1;
		s.value = '0;
		unique case (c) inside
			[8'h41:8'h5A]: s.value = 6'(c - 8'h41);
			[8'h61:8'h7A]: s.value = 6'(c - 8'd71);
			[8'h30:8'h39]: s.value = 6'(c + 8'd4);
			8'h2B: s.value = 6'd62;
			8'h2F: s.value = 6'd63;
			default: s.ok = 1'b0;
		endcase
		return s;
	endfunction

endpackage

// ===== hw/rtl/b64sc_if.sv =====
`timescale 1ns / 1ps

interface b64sc_in_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic end_of_message;

	modport source (output valid, output data_byte, output end_of_message, input ready);
	modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64sc_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic last_of_run;
	logic message_done;

	modport source (output valid, output out_byte, output last_of_run,
		output message_done, input ready);
	modport sink (input valid, input out_byte, input last_of_run,
		input message_done, output ready);
endinterface

interface b64sc_cfg_if;
	logic valid;
	logic ready;
	logic mode_decode;

	modport source (output valid, output mode_decode, input ready);
	modport sink (input valid, input mode_decode, output ready);
endinterface

// ===== hw/rtl/b64sc_front.sv =====
`timescale 1ns / 1ps

module b64sc_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] data_byte,
	input  logic end_of_message,
	input  logic cfg_valid,
	input  logic cfg_mode_decode,
	input  logic queue_full,
	output b64sc_pkg::push_t push
);

	logic mode_q;
	logic [1:0] phase_q;
	logic [5:0] carry_q;
	logic stopped_q;

	logic [1:0] nxt_phase;
	logic [5:0] nxt_carry;
	logic nxt_stopped;
	b64sc_pkg::run_t run;
	b64sc_pkg::symbol_t sym;
	logic accept;

	assign in_ready = !queue_full;
	assign accept = in_valid && in_ready;
	assign sym = b64sc_pkg::symbol_value(data_byte);

	always_comb begin
		run = '0;
		run.eom = end_of_message;
		nxt_phase = phase_q;
		nxt_carry = carry_q;
		nxt_stopped = stopped_q;
		if (!mode_q) begin
			unique case (phase_q)
				2'd0: begin
					run.chars[0] = b64sc_pkg::enc_char(data_byte[7:2]);
					run.count = 3'd1;
					nxt_carry = {4'b0, data_byte[1:0]};
					nxt_phase = 2'd1;
				end
				2'd1: begin
					run.chars[0] = b64sc_pkg::enc_char({carry_q[1:0], data_byte[7:4]});
					run.count = 3'd1;
					nxt_carry = {2'b0, data_byte[3:0]};
					nxt_phase = 2'd2;
				end
				default: begin
					run.chars[0] = b64sc_pkg::enc_char({carry_q[3:0], data_byte[7:6]});
					run.chars[1] = b64sc_pkg::enc_char(data_byte[5:0]);
					run.count = 3'd2;
					nxt_carry = '0;
					nxt_phase = 2'd0;
				end
			endcase
			// Flush a partial group with padding at the end of the message.
			if (end_of_message) begin
				if (phase_q == 2'd0) begin
					run.chars[1] = b64sc_pkg::enc_char({data_byte[1:0], 4'b0});
					run.chars[2] = b64sc_pkg::PAD_CHAR;
					run.chars[3] = b64sc_pkg::PAD_CHAR;
					run.count = 3'd4;
				end else if (phase_q == 2'd1) begin
					run.chars[1] = b64sc_pkg::enc_char({data_byte[3:0], 2'b0});
					run.chars[2] = b64sc_pkg::PAD_CHAR;
					run.count = 3'd3;
				end
			end
		end else if (!stopped_q) begin
			if (!sym.ok) begin
				nxt_stopped = 1'b1;
			end else begin
				unique case (phase_q)
					2'd0: begin
						nxt_carry = sym.value;
						nxt_phase = 2'd1;
					end
					2'd1: begin
						run.chars[0] = {carry_q, sym.value[5:4]};
						run.count = 3'd1;
						nxt_carry = {2'b0, sym.value[3:0]};
						nxt_phase = 2'd2;
					end
					2'd2: begin
						run.chars[0] = {carry_q[3:0], sym.value[5:2]};
						run.count = 3'd1;
						nxt_carry = {4'b0, sym.value[1:0]};
						nxt_phase = 2'd3;
					end
					default: begin
						run.chars[0] = {carry_q[1:0], sym.value};
						run.count = 3'd1;
						nxt_carry = '0;
						nxt_phase = 2'd0;
					end
				endcase
			end
		end
	end

	always_comb begin
		push.valid = accept && (run.count != '0);
		push.run = run;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			phase_q <= '0;
			carry_q <= '0;
			stopped_q <= 1'b0;
		end else if (cfg_valid) begin
			mode_q <= cfg_mode_decode;
			phase_q <= '0;
			carry_q <= '0;
			stopped_q <= 1'b0;
		end else if (accept) begin
			if (end_of_message) begin
				phase_q <= '0;
				carry_q <= '0;
				stopped_q <= 1'b0;
			end else begin
				phase_q <= nxt_phase;
				carry_q <= nxt_carry;
				stopped_q <= nxt_stopped;
			end
		end
	end

endmodule

// ===== hw/rtl/b64sc_fifo.sv =====
`timescale 1ns / 1ps

module b64sc_fifo #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  b64sc_pkg::push_t push,
	output logic full,
	input  logic pop,
	output logic empty,
	output b64sc_pkg::run_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	b64sc_pkg::run_t slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push.valid && !full;
	assign do_pop = pop && !empty;
	assign head = slots_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push.run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/b64sc_back.sv =====
`timescale 1ns / 1ps

module b64sc_back (
	input  logic clk,
	input  logic arst_n,
	input  logic queue_empty,
	input  b64sc_pkg::run_t head,
	output logic pop,
	output logic out_valid,
	input  logic out_ready,
	output logic [7:0] out_byte,
	output logic last_of_run,
	output logic message_done
);

	b64sc_pkg::run_t cur_q;
	logic [1:0] idx_q;
	logic busy_q;
	logic is_last;

	assign is_last = ({1'b0, idx_q} + 3'd1) == cur_q.count;
	assign out_valid = busy_q;
	assign out_byte = cur_q.chars[idx_q];
	assign last_of_run = is_last;
	assign message_done = is_last && cur_q.eom;

	// Take the next run when idle or when the last result of this one leaves.
	assign pop = !queue_empty && (!busy_q || (out_ready && is_last));

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q <= '0;
		end else if (busy_q && out_ready) begin
			if (is_last) begin
				busy_q <= 1'b0;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/base64_stream_codec_top.sv =====
`timescale 1ns / 1ps
// A run goes into the queue, then into the back end's register before its first result shows.
// The output side drives one result per cycle while out_ready is high; a request causes
// 1 to 4 results, and encoding gives four results per three input bytes.
// A request that produces no result leaves nothing in the queue.
// Reset (arst_n low, asynchronous) selects encode mode and clears the codec and queue state.

module base64_stream_codec_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	b64sc_in_if.sink in_ch,
	b64sc_out_if.source out_ch,
	b64sc_cfg_if.sink cfg
);

	// The front end classifies each request and computes every result it
	// causes in the cycle it accepts it, handing them over as one run to a short queue.
	// The back end drains runs one result at a time, so a stalled output only
	// backs up into the queue and the front end keeps accepting until it fills.

	b64sc_pkg::push_t push;
	b64sc_pkg::run_t head;
	logic queue_full;
	logic queue_empty;
	logic pop;

	// Mode writes must arrive only while the codec is idle, which the block does not enforce; they are always taken.
	assign cfg.ready = 1'b1;

	b64sc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.data_byte(in_ch.data_byte),
		.end_of_message(in_ch.end_of_message),
		.cfg_valid(cfg.valid),
		.cfg_mode_decode(cfg.mode_decode),
		.queue_full(queue_full),
		.push(push)
	);

	// Each queue entry holds the complete run of one request.
	b64sc_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(queue_full),
		.pop(pop),
		.empty(queue_empty),
		.head(head)
	);

	// The back end marks the final result of each run and, for the request
	// that ended the message, the final result of the message.
	b64sc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.queue_empty(queue_empty),
		.head(head),
		.pop(pop),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.out_byte(out_ch.out_byte),
		.last_of_run(out_ch.last_of_run),
		.message_done(out_ch.message_done)
	);

endmodule

// ===== hw/rtl/b64sc_checker.sv =====
`timescale 1ns / 1ps

module b64sc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [7:0] out_byte,
	input logic last_of_run,
	input logic message_done
);

	// The message ends only on the final result of a run.
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && message_done |-> last_of_run)
		else $error("message_done without last_of_run");

	// A stalled result keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte)
			&& $stable(last_of_run) && $stable(message_done))
		else $error("stalled result changed");

	// A full queue means the output side is already busy with a run.
	a_full_means_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled while output idle");

endmodule

bind base64_stream_codec_top b64sc_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_byte(out_ch.out_byte),
	.last_of_run(out_ch.last_of_run),
	.message_done(out_ch.message_done)
);
